[sv/temperature_rate_of_rise_alarm_unit_assert.svh]
// Assertion macros for the temperature rate-of-rise alarm unit.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef TEMPERATURE_RATE_OF_RISE_ALARM_UNIT_ASSERT_SVH
`define TEMPERATURE_RATE_OF_RISE_ALARM_UNIT_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define TRRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define TRRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/trra_pkg.sv]
// Package of the temperature rate-of-rise alarm unit: types and constants.
// Used by the history cell and the top level; depends on nothing.
`default_nettype none

package trra_pkg;

  // A temperature in signed 1/16 degree units.
  typedef logic signed [11:0] temp_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2,
    OP_RSVD    = 2'd3
  } op_e;

  // Controls handed from the top level to every history cell.
  typedef struct packed {
    logic fill;
    logic shift;
  } cell_ctl_t;

  // Sensor sentinel readings: 85.0 and -127.0 degrees.
  localparam temp_t SENT_HOT  = 12'sd1360;
  localparam temp_t SENT_COLD = -12'sd2032;

  // Register reset values.
  localparam logic [7:0] INTERVAL_RST  = 8'd50;
  localparam logic [7:0] THRESHOLD_RST = 8'd16;

  // Register index as decoded from paddr bit 2.
  localparam logic REG_INTERVAL  = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

endpackage

`default_nettype wire

[sv/trra_cell.sv]
// One history cell: holds a single temperature entry of the history line.
// Depends on trra_pkg.
`default_nettype none

module trra_cell
  import trra_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  temp_t     fill_i,
  input  temp_t     shift_i,
  output temp_t     value_o
);

  temp_t value_d, value_q;

  // A fill loads the sample; a shift takes the entry of the younger neighbor.
  always_comb begin
    value_d = value_q;
    if (ctl_i.fill) begin
      value_d = fill_i;
    end else if (ctl_i.shift) begin
      value_d = shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

[sv/temperature_rate_of_rise_alarm_unit.sv]
// Top level of the temperature rate-of-rise alarm unit.
// Depends on trra_pkg, trra_cell and temperature_rate_of_rise_alarm_unit_assert.svh.
`default_nettype none

// The unit takes one item per clock: a tick, an enable or a disable, each with
// a temperature sample in signed 1/16 degree units, and returns exactly one
// result per item. Every item is finished in the cycle of its transfer, since
// the latch, the count, the rise compare and the history shift all happen in
// that single step, and the result is registered for the output. The sustained
// rate is one item per clock, set by the output register and its one-entry skid
// stage: the input only stalls when both hold results that the downstream side
// has not yet taken. The history is a row of HISTORY_DEPTH identical cells; on
// a check each cell takes the entry of its younger neighbor and the youngest
// cell takes the latched reading, so the oldest entry always sits in cell zero.
// There is no clearing pass after reset. The two registers (check interval at
// byte address 0, rise threshold at 4) are written through the APB-style port;
// the user must do this only while the unit is idle, which is not enforced.

module temperature_rate_of_rise_alarm_unit
  import trra_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  temp_t       sample_i,
  // Result output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        alarm_o,
  output temp_t       latched_value_o,
  output logic        reading_ready_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] interval_q, threshold_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= INTERVAL_RST;
      threshold_q <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_INTERVAL:  interval_q  <= pwdata[7:0];
        REG_THRESHOLD: threshold_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INTERVAL:  prdata = {24'd0, interval_q};
      REG_THRESHOLD: prdata = {24'd0, threshold_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: output register plus one skid entry
  // ---------------------------------------------------------------------------
  logic in_acc, out_take;
  logic out_valid_q, skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  // ---------------------------------------------------------------------------
  // Control state and next-state logic
  // ---------------------------------------------------------------------------
  logic       enabled_d, enabled_q;
  logic       ready_d, ready_q;
  logic [7:0] count_d, count_q;
  logic [7:0] count_inc;
  temp_t      held_d, held_q;
  cell_ctl_t  cell_ctl;
  logic       check_fire;
  logic       res_alarm, res_ready;
  op_e        op;

  temp_t             hist_w [HISTORY_DEPTH];
  logic signed [13:0] rise_limit, held_ext;

  assign op        = op_e'(opcode_i);
  assign count_inc = count_q + 8'd1;

  // Oldest entry plus the allowed rise, compared exactly against the reading.
  assign rise_limit = $signed({{2{hist_w[0][11]}}, hist_w[0]}) + $signed({6'd0, threshold_q});
  assign held_ext   = $signed({{2{held_d[11]}}, held_d});

  always_comb begin
    enabled_d  = enabled_q;
    ready_d    = ready_q;
    count_d    = count_q;
    held_d     = held_q;
    cell_ctl   = '0;
    check_fire = 1'b0;
    res_alarm  = 1'b0;
    res_ready  = ready_q;
    if (in_acc) begin
      unique case (op)
        OP_TICK: begin
          if (enabled_q) begin
            // The first reading of the interval that is not a sentinel is held.
            if (!ready_q && sample_i != SENT_HOT && sample_i != SENT_COLD) begin
              held_d  = sample_i;
              ready_d = 1'b1;
            end
            res_ready = ready_d;
            if (count_inc >= interval_q) begin
              check_fire     = 1'b1;
              res_alarm      = rise_limit < held_ext;
              cell_ctl.shift = 1'b1;
              count_d        = '0;
              ready_d        = 1'b0;
            end else begin
              count_d = count_inc;
            end
          end
        end
        OP_ENABLE: begin
          // Enabling from the disabled state seeds the whole history.
          if (!enabled_q) begin
            cell_ctl.fill = 1'b1;
            held_d        = sample_i;
            count_d       = '0;
            enabled_d     = 1'b1;
          end
        end
        OP_DISABLE: begin
          enabled_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      ready_q   <= 1'b0;
      count_q   <= '0;
      held_q    <= '0;
    end else begin
      enabled_q <= enabled_d;
      ready_q   <= ready_d;
      count_q   <= count_d;
      held_q    <= held_d;
    end
  end

  // ---------------------------------------------------------------------------
  // History line: a chain of cells, cell zero holds the oldest entry
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    temp_t chain_in;
    if (g == HISTORY_DEPTH - 1) begin : g_tail
      assign chain_in = held_d;
    end else begin : g_link
      assign chain_in = hist_w[g + 1];
    end
    trra_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl),
      .fill_i  (sample_i),
      .shift_i (chain_in),
      .value_o (hist_w[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Result registers
  // ---------------------------------------------------------------------------
  logic  out_alarm_q, out_ready_q, skid_alarm_q, skid_ready_q;
  temp_t out_value_q, skid_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_alarm_q <= res_alarm;
        out_value_q <= held_d;
        out_ready_q <= res_ready;
      end else begin
        skid_alarm_q <= res_alarm;
        skid_value_q <= held_d;
        skid_ready_q <= res_ready;
      end
    end else if (out_take && skid_valid_q) begin
      out_alarm_q <= skid_alarm_q;
      out_value_q <= skid_value_q;
      out_ready_q <= skid_ready_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign alarm_o         = out_alarm_q;
  assign latched_value_o = out_value_q;
  assign reading_ready_o = out_ready_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "temperature_rate_of_rise_alarm_unit_assert.svh"

  // Checked during reset too; reset itself satisfies it, so flops that are
  // still unknown before the first reset edge cannot trip it.
  `TRRA_ASSERT_ALWAYS(a_skid_behind_out,
                      !rst_ni || !skid_valid_q || out_valid_q,
                      "skid entry without output entry")
  `TRRA_ASSERT(a_alarm_only_on_tick,
               !res_alarm || (in_acc && enabled_q && op == OP_TICK),
               "alarm outside an enabled tick")
  `TRRA_ASSERT(a_check_clears,
               (in_acc && check_fire) |=> (count_q == 8'd0 && !ready_q),
               "check did not clear count and flag")
  `TRRA_ASSERT(a_count_idle,
               (!enabled_q && !(in_acc && op == OP_ENABLE)) |=> $stable(count_q),
               "count moved while disabled")

endmodule

`default_nettype wire

[test/tb_temperature_rate_of_rise_alarm_unit.sv]
// Self-checking testbench for the temperature rate-of-rise alarm unit.
// Depends on trra_pkg and temperature_rate_of_rise_alarm_unit; reads no files.
`timescale 1ns / 100ps

module tb_temperature_rate_of_rise_alarm_unit;
  import trra_pkg::*;

  localparam int unsigned HISTORY_DEPTH = 10;

  // Longest receiver hold-off, used once per unthrottled phase to back the unit up.
  localparam int HOLD_OFF_CYCLES = 300;
  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 225;

  localparam temp_t T_MAX = 12'sd2047;
  localparam temp_t T_MIN = -12'sd2048;

  // One result of the unit as it should appear on the output channel.
  typedef struct {
    logic  alarm;
    temp_t latched;
    logic  ready;
  } alarm_result_t;

  // Scoreboard: keeps its own copy of the alarm state and the two registers,
  // turns every accepted input transfer into the result it must cause, and
  // holds those results in order until the output side delivers them.
  class rise_alarm_scoreboard;
    temp_t         history[HISTORY_DEPTH];
    logic [7:0]    tick_count;
    logic [7:0]    interval;
    logic [7:0]    threshold;
    temp_t         held;
    bit            ready;
    bit            enabled;
    alarm_result_t alarm_q[$];

    function new();
      foreach (history[i]) history[i] = '0;
      tick_count = '0;
      interval   = INTERVAL_RST;
      threshold  = THRESHOLD_RST;
      held       = '0;
      ready      = 1'b0;
      enabled    = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [7:0] value);
      if (idx == REG_INTERVAL) interval = value;
      else threshold = value;
    endfunction

    function void note_item(op_e op, temp_t s);
      alarm_result_t r;
      bit            ready_out;
      int            oldest;
      r.alarm   = 1'b0;
      ready_out = ready;
      case (op)
        OP_TICK: begin
          if (enabled) begin
            tick_count = tick_count + 8'd1;
            if (!ready && s != SENT_HOT && s != SENT_COLD) begin
              held  = s;
              ready = 1'b1;
            end
            ready_out = ready;
            if (tick_count >= interval) begin
              // Exact signed compare; the threshold is unsigned.
              oldest = history[0];
              if (oldest + int'(threshold) < int'(held)) r.alarm = 1'b1;
              for (int i = 0; i < HISTORY_DEPTH - 1; i++) history[i] = history[i + 1];
              history[HISTORY_DEPTH - 1] = held;
              tick_count = '0;
              ready      = 1'b0;
            end
          end
        end
        OP_ENABLE: begin
          if (!enabled) begin
            foreach (history[i]) history[i] = s;
            held       = s;
            tick_count = '0;
            enabled    = 1'b1;
          end
          ready_out = ready;
        end
        OP_DISABLE: begin
          enabled   = 1'b0;
          ready_out = ready;
        end
        default: ;
      endcase
      r.latched = held;
      r.ready   = ready_out;
      alarm_q.push_back(r);
    endfunction

    // Returns an empty string on a match, else a description of the failure.
    function string check_result(logic alarm, temp_t latched, logic rdy);
      alarm_result_t e;
      if (alarm_q.size() == 0) return "result arrived with no expectation pending";
      e = alarm_q.pop_front();
      if (alarm !== e.alarm || latched !== e.latched || rdy !== e.ready)
        return $sformatf("alarm %b/%b latched_value %0d/%0d reading_ready %b/%b (got/exp)",
                         alarm, e.alarm, latched, e.latched, rdy, e.ready);
      return "";
    endfunction

    function int pending();
      return alarm_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  temp_t       sample_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        alarm_o;
  temp_t       latched_value_o;
  logic        reading_ready_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rise_alarm_scoreboard sb;
  int    error_count    = 0;
  int    quiet_cycles   = 0;
  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;
  bit    hold_request   = 1'b0;
  string mismatch_text;

  temperature_rate_of_rise_alarm_unit #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alarm_o        (alarm_o),
    .latched_value_o(latched_value_o),
    .reading_ready_o(reading_ready_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 20 ns clock.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Offers one item, after a random number of idle cycles, and returns at the
  // rising edge where the transfer takes place. The payload is held while the
  // unit stalls.
  task automatic send_item(input op_e op, input temp_t s);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering items and waits until every expected result has arrived.
  // Every item yields a result, so an empty scoreboard means an idle unit.
  task automatic settle(input int extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready. The unused upper
  // data bits carry noise, since only the low byte is kept.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & 32'hFFFF_FF00) | {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: stalls at random at the rate of the current phase, or for a
  // long counted stretch when a hold-off is requested.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Monitor: both channels are sampled at the rising edge. Inputs are noted
  // before results are checked, so a result can never overtake its item.
  // The watchdog counts edges at which neither channel moves a transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(op_e'(opcode_i), sample_i);
      if (out_valid_o && !out_stall_i) begin
        mismatch_text = sb.check_result(alarm_o, latched_value_o, reading_ready_o);
        if (mismatch_text != "") report_mismatch(mismatch_text);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[temperature_rate_of_rise_alarm_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int         phase;
    int         n;
    int         pick;
    int         level;
    logic [7:0] interval;
    logic [7:0] threshold;
    op_e        op;
    temp_t      s;

    level      = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    opcode_i   = OP_TICK;
    sample_i   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    sb         = new();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, first at the reset register values: a tick, the reserved opcode
    // and a disable while disabled, the enable that fills the history, a second
    // enable that must be ignored, both sentinels skipped by the latch, a tick after
    // the latch, then disable, a tick that must change nothing and a new enable.
    send_item(OP_TICK, T_MAX);
    send_item(OP_RSVD, T_MIN);
    send_item(OP_DISABLE, 12'sd5);
    send_item(OP_ENABLE, 12'sd100);
    send_item(OP_ENABLE, 12'sd500);
    send_item(OP_TICK, SENT_HOT);
    send_item(OP_TICK, SENT_COLD);
    send_item(OP_TICK, T_MAX);
    send_item(OP_TICK, T_MIN);
    send_item(OP_RSVD, 12'sd7);
    send_item(OP_DISABLE, 12'sd0);
    send_item(OP_TICK, 12'sd33);
    send_item(OP_ENABLE, T_MIN);
    settle(4);

    // Short interval with no hysteresis. The ready flag survives the disable
    // and the enable, so the first interval latches nothing new and checks the
    // reading seeded by the enable, which must stay quiet; an interval of
    // sentinels then keeps that reading.
    write_reg(REG_INTERVAL, 8'd2);
    write_reg(REG_THRESHOLD, 8'd0);
    send_item(OP_TICK, T_MAX);
    send_item(OP_TICK, 12'sd0);
    send_item(OP_TICK, SENT_HOT);
    send_item(OP_TICK, SENT_COLD);
    settle(4);

    // A zero interval checks on every tick. With the largest hysteresis the
    // second tick lands exactly on the boundary and the third just above it.
    write_reg(REG_INTERVAL, 8'd0);
    write_reg(REG_THRESHOLD, 8'd255);
    send_item(OP_TICK, T_MIN);
    send_item(OP_TICK, -12'sd1793);
    send_item(OP_TICK, -12'sd1792);
    send_item(OP_TICK, T_MAX);
    settle(4);

    // Random part. Each phase takes a register setting and an idling pattern;
    // the unthrottled phases also start with a long receiver hold-off so the
    // output stage fills and the input stalls while items keep coming.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin interval = 8'd1;   threshold = 8'd0;   end
        1: begin interval = 8'd255; threshold = 8'd255; end
        2: begin interval = 8'd4;   threshold = 8'd16;  end
        3: begin interval = 8'd0;   threshold = 8'd40;  end
        4: begin
          interval  = 8'($urandom_range(8, 1));
          threshold = 8'($urandom_range(255));
        end
        5: begin interval = 8'd2;   threshold = 8'd128; end
        6: begin interval = INTERVAL_RST; threshold = THRESHOLD_RST; end
        default: begin
          interval  = 8'($urandom_range(6, 1));
          threshold = 8'($urandom_range(64));
        end
      endcase
      write_reg(REG_INTERVAL, interval);
      write_reg(REG_THRESHOLD, threshold);

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (phase % 4 == 0) hold_request = 1'b1;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Mostly ticks, so the unit spends most of its time enabled and
        // working through intervals; the other opcodes are kept rare.
        pick = $urandom_range(99);
        if (pick < 84) op = OP_TICK;
        else if (pick < 90) op = OP_ENABLE;
        else if (pick < 96) op = OP_DISABLE;
        else op = OP_RSVD;

        // Samples: sentinels, the two extremes, a slowly rising temperature
        // that produces genuine alarms, and plain noise over the full range.
        pick = $urandom_range(99);
        if (pick < 6) s = SENT_HOT;
        else if (pick < 12) s = SENT_COLD;
        else if (pick < 16) s = T_MAX;
        else if (pick < 20) s = T_MIN;
        else if (pick < 60) begin
          level = level + int'($urandom_range(24)) - 8;
          s     = temp_t'(level);
          level = s;
        end else s = temp_t'($urandom);
        send_item(op, s);
      end
      settle(4);
    end

    // Any stray result during this tail shows up as a failure.
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[temperature_rate_of_rise_alarm_unit] OK");
    end else begin
      $display("[temperature_rate_of_rise_alarm_unit] ERROR");
    end
    $finish;
  end

endmodule
